// File: hw/rtl/biquadratic_root_solver_top_assert.svh
// Assertion macros used by the biquadratic root solver checker.
`ifndef BIQUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH
`define BIQUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define BQRS_ASSERT_NOW(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Condition that must hold in the cycle after the antecedent.
`define BQRS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/bqrs_pkg.sv
// Package with widths and status codes of the biquadratic root solver.
`timescale 1ns / 1ps
package bqrs_pkg;
   localparam int COEF_W   = 16;
   localparam int ROOT_W   = 32;
   localparam int COUNT_W  = 3;
   localparam int STATUS_W = 2;
   localparam int MAX_ROOTS = 4;
   localparam int DISC_W   = 34;
   localparam int DIV_NW   = 34;
   localparam int DIV_DW   = 17;
   localparam int TSQ_W    = 50;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_A_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAT    = 2'd2;
endpackage

// File: hw/rtl/bqrs_isqrt.sv
// Pipelined floor integer square root, one result bit per stage.
`timescale 1ns / 1ps
module bqrs_isqrt #(
   parameter int W = 34
) (
   input  logic           clock,
   input  logic           en,
   input  logic [W-1:0]   din,
   output logic [W/2-1:0] dout
);
   localparam int NS = W / 2;

   logic [W-1:0] n_ff [NS];
   logic [W-1:0] r_ff [NS];

   genvar j;
   generate
      for (j = 0; j < NS; j++) begin : g_stage
         localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * j);
         logic [W-1:0] n_prev;
         logic [W-1:0] r_prev;
         logic [W-1:0] trial;
         logic [W-1:0] n_in;
         logic [W-1:0] r_in;

         if (j == 0) begin : g_first
            assign n_prev = din;
            assign r_prev = '0;
         end else begin : g_next
            assign n_prev = n_ff[j-1];
            assign r_prev = r_ff[j-1];
         end

         always_comb begin
            trial = r_prev + BIT;
            if (n_prev >= trial) begin
               n_in = n_prev - trial;
               r_in = (r_prev >> 1) + BIT;
            end else begin
               n_in = n_prev;
               r_in = r_prev >> 1;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               n_ff[j] <= n_in;
               r_ff[j] <= r_in;
            end
         end
      end
   endgenerate

   assign dout = r_ff[NS-1][NS-1:0];
endmodule

// File: hw/rtl/bqrs_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
`timescale 1ns / 1ps
module bqrs_div #(
   parameter int NW = 34,
   parameter int DW = 17
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [NW-1:0] quo
);
   logic [NW-1:0] n_ff [NW];
   logic [NW-1:0] q_ff [NW];
   logic [DW-1:0] r_ff [NW];
   logic [DW-1:0] d_ff [NW];

   genvar j;
   generate
      for (j = 0; j < NW; j++) begin : g_stage
         localparam logic [NW-1:0] QBIT = {{(NW-1){1'b0}}, 1'b1} << (NW - 1 - j);
         logic [NW-1:0] n_prev;
         logic [NW-1:0] q_prev;
         logic [DW-1:0] r_prev;
         logic [DW-1:0] d_prev;
         logic [DW:0]   shifted;
         logic [DW:0]   diff;
         logic [DW-1:0] r_in;
         logic [NW-1:0] q_in;

         if (j == 0) begin : g_first
            assign n_prev = num;
            assign q_prev = '0;
            assign r_prev = '0;
            assign d_prev = den;
         end else begin : g_next
            assign n_prev = n_ff[j-1];
            assign q_prev = q_ff[j-1];
            assign r_prev = r_ff[j-1];
            assign d_prev = d_ff[j-1];
         end

         always_comb begin
            shifted = {r_prev, n_prev[NW-1-j]};
            diff    = shifted - {1'b0, d_prev};
            if (shifted >= {1'b0, d_prev}) begin
               r_in = diff[DW-1:0];
               q_in = q_prev | QBIT;
            end else begin
               r_in = shifted[DW-1:0];
               q_in = q_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               n_ff[j] <= n_prev;
               q_ff[j] <= q_in;
               r_ff[j] <= r_in;
               d_ff[j] <= d_prev;
            end
         end
      end
   endgenerate

   assign quo = q_ff[NW-1];
endmodule

// File: hw/rtl/biquadratic_root_solver_top.sv
// Top level of the biquadratic root solver: pipeline and root serializer.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  coef_a, coef_b, coef_c
//   rsp      out        rsp_valid/rsp_ready  root_value, root_valid, root_count,
//                                            status, last
//
// A transaction enters every cycle unless the pipeline is stalled; the pipeline is
// 80 stages deep before the serializer, which sends one to four result transactions
// per equation, one per cycle while rsp_ready is high.
// The depth is set by the discriminant square root, the two dividers and the two
// root square roots, each producing one bit per stage.
// Reset clears all valid bits; a stall at rsp freezes the whole pipeline only while its last stage is valid.
`timescale 1ns / 1ps
module biquadratic_root_solver_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [bqrs_pkg::COEF_W-1:0]    req_coef_a,
   input  logic signed [bqrs_pkg::COEF_W-1:0]    req_coef_b,
   input  logic signed [bqrs_pkg::COEF_W-1:0]    req_coef_c,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [bqrs_pkg::ROOT_W-1:0]    rsp_root_value,
   output logic                                  rsp_root_valid,
   output logic [bqrs_pkg::COUNT_W-1:0]          rsp_root_count,
   output logic [bqrs_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                  rsp_last
);
   import bqrs_pkg::*;

   localparam int SQ1_NS = DISC_W / 2;
   localparam int SQ2_NS = TSQ_W / 2;

   typedef struct packed {
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
      logic                     d_neg;
      logic                     d_zero;
   } sba_type;

   typedef struct packed {
      logic a_zero;
      logic d_neg;
      logic d_zero;
      logic neg1;
      logic neg2;
   } sbb_type;

   typedef struct packed {
      logic a_zero;
      logic d_neg;
      logic d_zero;
      logic pos1;
      logic z1;
      logic pos2;
      logic z2;
   } sbc_type;

   logic en;
   logic ser_free;
   logic load;

   logic                     v0_ff, v1_ff, v2_ff, v3_ff;
   logic signed [COEF_W-1:0] a0_ff, b0_ff, c0_ff, a1_ff, b1_ff, a2_ff, b2_ff;
   logic signed [31:0]       bb1_ff, ac1_ff, bb_in, ac_in;
   logic signed [34:0]       d2_ff, d_in;
   logic [DISC_W-1:0]        sq1_din;
   logic [SQ1_NS-1:0]        sq1_dout;

   logic    va_ff [SQ1_NS];
   sba_type sba_ff [SQ1_NS];
   sba_type sba_src;

   logic signed [18:0] nb, s_ext, num1, num2, mag1, mag2;
   logic signed [16:0] a_ext, amag;
   logic [DIV_NW-1:0]  n1_ff, n2_ff;
   logic [DIV_DW-1:0]  den_ff;
   sbb_type            sb3_ff, sb3_in;
   logic [DIV_NW-1:0]  q1, q2;

   logic    vb_ff [DIV_NW];
   sbb_type sbb_ff [DIV_NW];

   sbc_type         sbc_src;
   logic            vc_ff [SQ2_NS];
   sbc_type         sbc_ff [SQ2_NS];
   logic [SQ2_NS-1:0] r1, r2;

   logic busy_ff;
   logic [1:0] idx_ff;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [STATUS_W-1:0] stat_ff, stat_in;
   logic signed [ROOT_W-1:0] vals_ff [MAX_ROOTS];
   logic signed [ROOT_W-1:0] vals_in [MAX_ROOTS];
   logic signed [ROOT_W-1:0] r1_ext, r2_ext;
   logic last_now;

   sbc_type sbe;
   logic    v_end;

   assign sbe   = sbc_ff[SQ2_NS-1];
   assign v_end = vc_ff[SQ2_NS-1];

   assign last_now  = (cnt_ff == '0) || (({1'b0, idx_ff} + 3'd1) == cnt_ff);
   assign ser_free  = !busy_ff || (rsp_ready && last_now);
   assign en        = !v_end || ser_free;
   assign load      = v_end && ser_free;
   assign req_ready = en;

   // Front stages: capture, products, discriminant.
   assign bb_in = b0_ff * b0_ff;
   assign ac_in = a0_ff * c0_ff;
   assign d_in  = 35'(bb1_ff) - (35'(ac1_ff) <<< 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= va_ff[SQ1_NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a0_ff  <= req_coef_a;
         b0_ff  <= req_coef_b;
         c0_ff  <= req_coef_c;
         a1_ff  <= a0_ff;
         b1_ff  <= b0_ff;
         bb1_ff <= bb_in;
         ac1_ff <= ac_in;
         a2_ff  <= a1_ff;
         b2_ff  <= b1_ff;
         d2_ff  <= d_in;
      end
   end

   assign sq1_din = d2_ff[34] ? '0 : d2_ff[DISC_W-1:0];

   bqrs_isqrt #(.W(DISC_W)) u_sqrt_disc (
      .clock (clock),
      .en    (en),
      .din   (sq1_din),
      .dout  (sq1_dout)
   );

   assign sba_src = '{a: a2_ff, b: b2_ff, d_neg: d2_ff[34], d_zero: (d2_ff == '0)};

   genvar k;
   generate
      for (k = 0; k < SQ1_NS; k++) begin : g_dla
         always_ff @(posedge clock) begin
            if (reset) begin
               va_ff[k] <= 1'b0;
            end else if (en) begin
               va_ff[k] <= (k == 0) ? v2_ff : va_ff[(k == 0) ? 0 : k-1];
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               sba_ff[k] <= (k == 0) ? sba_src : sba_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   endgenerate

   // Numerators -b +/- s and divisor |2a|, split into sign and magnitude.
   always_comb begin
      nb     = -19'(sba_ff[SQ1_NS-1].b);
      s_ext  = {2'b00, sq1_dout};
      num1   = nb + s_ext;
      num2   = nb - s_ext;
      mag1   = num1[18] ? -num1 : num1;
      mag2   = num2[18] ? -num2 : num2;
      a_ext  = 17'(sba_ff[SQ1_NS-1].a);
      amag   = a_ext[16] ? -a_ext : a_ext;
      sb3_in = '{a_zero: (sba_ff[SQ1_NS-1].a == '0),
                 d_neg:  sba_ff[SQ1_NS-1].d_neg,
                 d_zero: sba_ff[SQ1_NS-1].d_zero,
                 neg1:   num1[18] ^ sba_ff[SQ1_NS-1].a[COEF_W-1],
                 neg2:   num2[18] ^ sba_ff[SQ1_NS-1].a[COEF_W-1]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_ff  <= {mag1[17:0], 16'h0000};
         n2_ff  <= {mag2[17:0], 16'h0000};
         den_ff <= {amag[15:0], 1'b0};
         sb3_ff <= sb3_in;
      end
   end

   bqrs_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_1 (
      .clock (clock), .en (en), .num (n1_ff), .den (den_ff), .quo (q1)
   );

   bqrs_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_2 (
      .clock (clock), .en (en), .num (n2_ff), .den (den_ff), .quo (q2)
   );

   generate
      for (k = 0; k < DIV_NW; k++) begin : g_dlb
         always_ff @(posedge clock) begin
            if (reset) begin
               vb_ff[k] <= 1'b0;
            end else if (en) begin
               vb_ff[k] <= (k == 0) ? v3_ff : vb_ff[(k == 0) ? 0 : k-1];
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               sbb_ff[k] <= (k == 0) ? sb3_ff : sbb_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   endgenerate

   assign sbc_src = '{a_zero: sbb_ff[DIV_NW-1].a_zero,
                      d_neg:  sbb_ff[DIV_NW-1].d_neg,
                      d_zero: sbb_ff[DIV_NW-1].d_zero,
                      pos1:   (q1 != '0) && !sbb_ff[DIV_NW-1].neg1,
                      z1:     (q1 == '0),
                      pos2:   (q2 != '0) && !sbb_ff[DIV_NW-1].neg2,
                      z2:     (q2 == '0)};

   bqrs_isqrt #(.W(TSQ_W)) u_sqrt_t1 (
      .clock (clock), .en (en), .din ({q1, 16'h0000}), .dout (r1)
   );

   bqrs_isqrt #(.W(TSQ_W)) u_sqrt_t2 (
      .clock (clock), .en (en), .din ({q2, 16'h0000}), .dout (r2)
   );

   generate
      for (k = 0; k < SQ2_NS; k++) begin : g_dlc
         always_ff @(posedge clock) begin
            if (reset) begin
               vc_ff[k] <= 1'b0;
            end else if (en) begin
               vc_ff[k] <= (k == 0) ? vb_ff[DIV_NW-1] : vc_ff[(k == 0) ? 0 : k-1];
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               sbc_ff[k] <= (k == 0) ? sbc_src : sbc_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   endgenerate

   // Root list assembly. A double root of t only uses the first quotient.
   assign r1_ext = ROOT_W'({1'b0, r1});
   assign r2_ext = ROOT_W'({1'b0, r2});

   always_comb begin
      logic use1;
      logic use2;
      logic p1;
      logic p2;
      logic zr;
      use1 = !sbe.a_zero && !sbe.d_neg;
      use2 = use1 && !sbe.d_zero;
      p1   = use1 && sbe.pos1;
      p2   = use2 && sbe.pos2;
      zr   = (use1 && sbe.z1) || (use2 && sbe.z2);
      for (int i = 0; i < MAX_ROOTS; i++) begin
         vals_in[i] = '0;
      end
      cnt_in = '0;
      if (p1) begin
         vals_in[0] = r1_ext;
         vals_in[1] = -r1_ext;
         cnt_in     = 3'd2;
      end
      if (p2) begin
         if (p1) begin
            vals_in[2] = r2_ext;
            vals_in[3] = -r2_ext;
         end else begin
            vals_in[0] = r2_ext;
            vals_in[1] = -r2_ext;
         end
         cnt_in = cnt_in + 3'd2;
      end
      if (zr && (cnt_in < 3'd4)) begin
         cnt_in = cnt_in + 3'd1;
      end
      stat_in = sbe.a_zero ? STATUS_A_ZERO : STATUS_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (busy_ff && rsp_ready) begin
         if (last_now) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cnt_ff  <= cnt_in;
         stat_ff <= stat_in;
         for (int i = 0; i < MAX_ROOTS; i++) begin
            vals_ff[i] <= vals_in[i];
         end
      end
   end

   assign rsp_valid      = busy_ff;
   assign rsp_root_value = vals_ff[idx_ff];
   assign rsp_root_valid = (cnt_ff != '0);
   assign rsp_root_count = cnt_ff;
   assign rsp_status     = stat_ff;
   assign rsp_last       = last_now;
endmodule

// File: hw/rtl/bqrs_checker.sv
// Port-level checker of the biquadratic root solver, with its bind.
`timescale 1ns / 1ps
`include "biquadratic_root_solver_top_assert.svh"
module bqrs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic signed [bqrs_pkg::COEF_W-1:0]  req_coef_a,
   input logic signed [bqrs_pkg::COEF_W-1:0]  req_coef_b,
   input logic signed [bqrs_pkg::COEF_W-1:0]  req_coef_c,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [bqrs_pkg::ROOT_W-1:0]  rsp_root_value,
   input logic                                rsp_root_valid,
   input logic [bqrs_pkg::COUNT_W-1:0]        rsp_root_count,
   input logic [bqrs_pkg::STATUS_W-1:0]       rsp_status,
   input logic                                rsp_last
);
   import bqrs_pkg::*;

   `BQRS_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req_coef_a) && $stable(req_coef_b) && $stable(req_coef_c), "req transaction changed while stalled")
   `BQRS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_root_value) && $stable(rsp_last), "rsp transaction changed while stalled")
   `BQRS_ASSERT_NOW(a_empty_single, !rsp_valid || rsp_root_valid || (rsp_last && (rsp_root_count == 0)), "rootless transaction is not a single empty item")
   `BQRS_ASSERT_NOW(a_count_range, !rsp_valid || !rsp_root_valid || ((rsp_root_count != 0) && (rsp_root_count <= MAX_ROOTS) && (rsp_status != STATUS_A_ZERO)), "root count out of range")
   `BQRS_ASSERT_NEXT(a_group_same, rsp_valid && rsp_ready && !rsp_last, rsp_valid && (rsp_root_count == $past(rsp_root_count)) && (rsp_status == $past(rsp_status)), "root group broken")
endmodule

bind biquadratic_root_solver_top bqrs_checker u_bqrs_checker (.*);
